/* rtl/pll_divider_search_defines.svh */
// assertion macros for the pll divider search block
// used by the top level only; expects clk and rst_n in scope
`ifndef PLL_DIVIDER_SEARCH_DEFINES_SVH
`define PLL_DIVIDER_SEARCH_DEFINES_SVH

// checked only out of reset
`define PDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/pds_pkg.sv */
// constants, reciprocal table and seed rom for the pll divider search
// no dependencies
package pds_pkg;

  localparam int unsigned RefW    = 17;
  localparam int unsigned MhzW    = 11;
  localparam int unsigned MW      = 7;
  localparam int unsigned PW      = 3;
  localparam int unsigned SeedW   = 9;
  localparam int unsigned ProdW   = 24;  // m * ref stays below 2^24
  localparam int unsigned TgtW    = 21;  // 1150 * 1000
  localparam int unsigned RecipW  = 27;
  localparam int unsigned RecipSh = 27;
  localparam int unsigned MulW    = ProdW + RecipW;

  localparam logic [MhzW-1:0] TargetMin = MhzW'(300);
  localparam logic [MhzW-1:0] TargetMax = MhzW'(1150);
  localparam logic [MW-1:0]   MFirst    = MW'(62);
  localparam logic [MW-1:0]   MLast     = MW'(92);
  localparam logic [PW-1:0]   PFirst    = PW'(2);
  localparam logic [PW-1:0]   PLast     = PW'(6);
  localparam logic [RefW-1:0] RefReset  = RefW'(25000);

  typedef enum logic [PW-1:0] {
    P_DIV2 = 3'd2,
    P_DIV3 = 3'd3,
    P_DIV4 = 3'd4,
    P_DIV5 = 3'd5,
    P_DIV6 = 3'd6
  } p_code_t;

  // ceil(2^27 / p); exact floor for any dividend below 2^24
  function automatic logic [RecipW-1:0] recip(input logic [PW-1:0] p);
    logic [RecipW-1:0] r;
    case (p)
      P_DIV2:  r = RecipW'(67108864);
      P_DIV3:  r = RecipW'(44739243);
      P_DIV4:  r = RecipW'(33554432);
      P_DIV5:  r = RecipW'(26843546);
      P_DIV6:  r = RecipW'(22369622);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [SeedW-1:0] seed_of(input logic [MW-1:0] m);
    logic [4:0] idx;
    logic [SeedW-1:0] s;
    idx = 5'(m - MFirst);
    case (idx)
      5'd0:  s = 9'd426;  5'd1:  s = 9'd469;  5'd2:  s = 9'd234;
      5'd3:  s = 9'd373;  5'd4:  s = 9'd442;  5'd5:  s = 9'd221;
      5'd6:  s = 9'd110;  5'd7:  s = 9'd311;  5'd8:  s = 9'd411;
      5'd9:  s = 9'd461;  5'd10: s = 9'd486;  5'd11: s = 9'd243;
      5'd12: s = 9'd377;  5'd13: s = 9'd188;  5'd14: s = 9'd350;
      5'd15: s = 9'd175;  5'd16: s = 9'd343;  5'd17: s = 9'd427;
      5'd18: s = 9'd213;  5'd19: s = 9'd106;  5'd20: s = 9'd53;
      5'd21: s = 9'd282;  5'd22: s = 9'd397;  5'd23: s = 9'd454;
      5'd24: s = 9'd227;  5'd25: s = 9'd113;  5'd26: s = 9'd56;
      5'd27: s = 9'd284;  5'd28: s = 9'd142;  5'd29: s = 9'd71;
      5'd30: s = 9'd35;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

/* rtl/pll_divider_search.sv */
// pll divider search top level: m/p search for a wanted link clock
// depends on pds_pkg and pll_divider_search_defines.svh
//
// usage
//   cfg channel: one write sets ref_clock_khz (reset value 25000); write only
//   while the block is idle. cfg_ready is always high.
//   in channel: one request carries target_mhz. in_ready is high only while
//   the sequencer is idle, so one request is worked on at a time.
//   out channel: one result per request, held in an output register until
//   taken; a new request may be accepted while that result still waits.
// flow
//   out-of-range target: no search, straight to the final state.
//   in range: one (m, p) candidate a cycle into the shared 24x27 reciprocal
//   multiplier, 155 at most; each candidate is judged from the pipeline
//   register, and the final state writes the result register, after which
//   the next request can be taken; an exact match ends the walk early.
// reset: synchronous, rst_n low returns the sequencer to idle, drops
//   out_valid and restores the reference clock value.
// stall: while out_ready is low the finished result holds; a search that
//   ends meanwhile waits in its final state until the register frees.
`include "pll_divider_search_defines.svh"

module pll_divider_search
  import pds_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [RefW-1:0]  cfg_ref_clock_khz,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [MhzW-1:0]  in_target_mhz,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_status,
  output logic [MW-1:0]    out_m_divider,
  output logic [SeedW-1:0] out_m_seed,
  output logic [PW-1:0]    out_p_divider,
  output logic             out_n_divider
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FIN
  } state_t;

  state_t            state_r;
  logic [RefW-1:0]   ref_r;
  logic [TgtW-1:0]   tgt_r;
  logic              range_err_r;
  logic [MW-1:0]     m_r;
  logic [PW-1:0]     p_r;
  logic [ProdW-1:0]  prod_r;
  logic              issued_all_r;
  logic              s_valid_r;
  logic [MulW-1:0]   s_mul_r;
  logic [MW-1:0]     s_m_r;
  logic [PW-1:0]     s_p_r;
  logic [ProdW-1:0]  best_err_r;
  logic [MW-1:0]     best_m_r;
  logic [PW-1:0]     best_p_r;
  logic              out_valid_r;
  logic              out_status_r;
  logic [MW-1:0]     out_m_r;
  logic [SeedW-1:0]  out_seed_r;
  logic [PW-1:0]     out_p_r;
  logic              out_n_r;

  logic              in_req;
  logic              in_range;
  logic [ProdW-1:0]  cand;
  logic [ProdW-1:0]  err;
  logic              better;
  logic              exact;
  logic              out_free;
  logic [ProdW-1:0]  ref_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_req    = in_valid && in_ready;
  assign in_range  = (in_target_mhz >= TargetMin) && (in_target_mhz <= TargetMax);
  assign out_free  = !out_valid_r || out_ready;
  assign ref_ext   = ProdW'(ref_r);

  // evaluate the candidate in the pipeline register
  assign cand   = s_mul_r[MulW-1:RecipSh];
  assign err    = (cand > ProdW'(tgt_r)) ? (cand - ProdW'(tgt_r)) : (ProdW'(tgt_r) - cand);
  assign better = s_valid_r && (err < best_err_r);
  assign exact  = s_valid_r && (err == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ref_r        <= RefReset;
      s_valid_r    <= 1'b0;
      issued_all_r <= 1'b0;
      range_err_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ref_r <= cfg_ref_clock_khz;
      end
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      s_valid_r <= (state_r == ST_SEARCH) && !issued_all_r;

      unique case (state_r)
        ST_IDLE: begin
          if (in_req) begin
            tgt_r        <= TgtW'(in_target_mhz) * TgtW'(1000);
            range_err_r  <= !in_range;
            m_r          <= MFirst;
            p_r          <= PFirst;
            prod_r       <= (ref_ext << 6) - (ref_ext << 1);
            issued_all_r <= 1'b0;
            best_err_r   <= '1;
            best_m_r     <= MFirst;
            best_p_r     <= PFirst;
            state_r      <= in_range ? ST_SEARCH : ST_FIN;
          end
        end

        ST_SEARCH: begin
          // issue side: one candidate a cycle into the multiplier
          if (!issued_all_r) begin
            s_mul_r   <= MulW'(prod_r) * MulW'(recip(p_r));
            s_m_r     <= m_r;
            s_p_r     <= p_r;
            if (p_r == PLast) begin
              p_r    <= PFirst;
              m_r    <= m_r + MW'(1);
              prod_r <= prod_r + ref_ext;
              if (m_r == MLast) begin
                issued_all_r <= 1'b1;
              end
            end else begin
              p_r <= p_r + PW'(1);
            end
          end
          // evaluate side
          if (better) begin
            best_err_r <= err;
            best_m_r   <= s_m_r;
            best_p_r   <= s_p_r;
          end
          if (exact || (issued_all_r && !s_valid_r)) begin
            state_r <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (out_free) begin
            out_status_r <= range_err_r;
            out_m_r      <= range_err_r ? '0 : best_m_r;
            out_seed_r   <= range_err_r ? '0 : seed_of(best_m_r);
            out_p_r      <= range_err_r ? '0 : best_p_r;
            out_n_r      <= !range_err_r;
            state_r      <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_m_divider = out_m_r;
  assign out_m_seed    = out_seed_r;
  assign out_p_divider = out_p_r;
  assign out_n_divider = out_n_r;

  `PDS_ASSERT(a_err_zero, (out_valid && out_status) |->
    (out_m_divider == '0 && out_p_divider == '0 && out_m_seed == '0 && !out_n_divider),
    "error result has nonzero dividers")
  `PDS_ASSERT(a_ok_range, (out_valid && !out_status) |->
    (out_m_divider >= MFirst && out_m_divider <= MLast && out_p_divider >= PFirst &&
     out_p_divider <= PLast && out_n_divider),
    "ok result outside divider range")
  `PDS_ASSERT(a_busy_after_req, (in_valid && in_ready) |=> !in_ready,
    "request accepted while search still running")
  `PDS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (in_ready && !out_valid),
    "reset did not return to idle")

endmodule

/* test/pll_divider_search_checker.sv */
// checker for the pll divider search: watches the config, request and result channels,
// predicts each result from its own copy of the reference clock and counts mismatches
// depends on pds_pkg for widths and search limits
module pll_divider_search_checker
  import pds_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [RefW-1:0]  cfg_ref_clock_khz,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [MhzW-1:0]  in_target_mhz,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             out_status,
  input  logic [MW-1:0]    out_m_divider,
  input  logic [SeedW-1:0] out_m_seed,
  input  logic [PW-1:0]    out_p_divider,
  input  logic             out_n_divider,
  output int               n_errors,
  output int               n_waiting,
  output int               n_checked
);

  localparam logic StatusOk    = 1'b0;
  localparam logic StatusRange = 1'b1;
  localparam logic NDivOk      = 1'b1;

  // lfsr seed per feedback divider, first entry is m = 62
  localparam logic [SeedW-1:0] SeedByM [31] = '{
    426, 469, 234, 373, 442, 221, 110, 311, 411, 461, 486,
    243, 377, 188, 350, 175, 343, 427, 213, 106, 53, 282,
    397, 454, 227, 113, 56, 284, 142, 71, 35
  };

  typedef struct packed {
    logic             status;
    logic [MW-1:0]    m_div;
    logic [SeedW-1:0] seed;
    logic [PW-1:0]    p_div;
    logic             n_div;
  } divider_set_t;

  divider_set_t    pending_sets[$];
  logic [RefW-1:0] ref_khz;
  int              mismatches = 0;
  int              checked = 0;

  function automatic divider_set_t search_dividers(input logic [MhzW-1:0] mhz,
                                                   input logic [RefW-1:0] ref_clock);
    divider_set_t    best;
    longint unsigned goal, cand, err, best_err;
    bit              exact;
    best = '0;
    if (mhz < TargetMin || mhz > TargetMax) begin
      best.status = StatusRange;
      return best;
    end
    goal     = 64'(mhz) * 64'd1000;
    best_err = '1;
    exact    = 1'b0;
    best.m_div = MFirst;
    best.p_div = PFirst;
    // m outer, p inner; strict compare keeps the first of equal errors
    for (int m = MFirst; m <= MLast && !exact; m++) begin
      for (int p = PFirst; p <= PLast && !exact; p++) begin
        cand = (64'(m) * 64'(ref_clock)) / 64'(p);
        err  = (cand > goal) ? cand - goal : goal - cand;
        if (err < best_err) begin
          best_err   = err;
          best.m_div = MW'(m);
          best.p_div = PW'(p);
        end
        if (err == 0) exact = 1'b1;
      end
    end
    best.status = StatusOk;
    best.seed   = SeedByM[best.m_div - MFirst];
    best.n_div  = NDivOk;
    return best;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    divider_set_t want;
    if (!rst_n) begin
      ref_khz = RefReset;
      pending_sets.delete();
    end else begin
      // results first: a request taken on this edge cannot have its result yet
      if (out_valid && out_ready) begin
        if (pending_sets.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding (m %0d p %0d)",
                                    out_m_divider, out_p_divider));
        end else begin
          want = pending_sets.pop_front();
          checked++;
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_m_divider !== want.m_div)
            report_mismatch($sformatf("m %0d, expected %0d", out_m_divider, want.m_div));
          if (out_m_seed !== want.seed)
            report_mismatch($sformatf("seed %0d, expected %0d", out_m_seed, want.seed));
          if (out_p_divider !== want.p_div)
            report_mismatch($sformatf("p %0d, expected %0d", out_p_divider, want.p_div));
          if (out_n_divider !== want.n_div)
            report_mismatch($sformatf("n %0d, expected %0d", out_n_divider, want.n_div));
        end
      end
      if (in_valid && in_ready)
        pending_sets.push_back(search_dividers(in_target_mhz, ref_khz));
      if (cfg_valid && cfg_ready)
        ref_khz = cfg_ref_clock_khz;
    end
    n_errors  <= mismatches;
    n_waiting <= pending_sets.size();
    n_checked <= checked;
  end

endmodule

/* test/tb_pll_divider_search.sv */
// testbench top for the pll divider search: drives config writes and target requests
// with random idling on both sides, then gives the verdict from the checker's counts
// depends on pds_pkg, pll_divider_search and pll_divider_search_checker
module tb_pll_divider_search;
  import pds_pkg::*;

  localparam int ResetCycles      = 7;
  localparam int StallLimit       = 4000;
  localparam int DrainCycles      = 8;
  localparam int ItemsPerSetting  = 165;
  localparam int SettingsPerPhase = 4;
  localparam int InRangePct       = 80;
  localparam logic [RefW-1:0] RefLow  = RefW'(1000);
  localparam logic [RefW-1:0] RefHigh = RefW'(100000);
  localparam logic [RefW-1:0] RefTop  = '1;
  localparam logic [MhzW-1:0] MhzTop  = '1;

  // range edges, exact hits at the reset reference clock and alternating bit patterns
  localparam logic [MhzW-1:0] EdgeTargets [13] = '{
    0, 299, 300, 301, 775, 1000, 1024, 1149, 1150, 1151, 682, 1365, 2047
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [RefW-1:0]  cfg_ref_clock_khz = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [MhzW-1:0]  in_target_mhz = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_status;
  logic [MW-1:0]    out_m_divider;
  logic [SeedW-1:0] out_m_seed;
  logic [PW-1:0]    out_p_divider;
  logic             out_n_divider;

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int n_errors, n_waiting, n_checked;
  int targets_sent = 0;
  int out_of_range_sent = 0;
  int ref_writes = 0;
  int quiet_cycles = 0;

  pll_divider_search u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_ref_clock_khz (cfg_ref_clock_khz),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_target_mhz     (in_target_mhz),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_m_divider     (out_m_divider),
    .out_m_seed        (out_m_seed),
    .out_p_divider     (out_p_divider),
    .out_n_divider     (out_n_divider)
  );

  pll_divider_search_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_ref_clock_khz (cfg_ref_clock_khz),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_target_mhz     (in_target_mhz),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_m_divider     (out_m_divider),
    .out_m_seed        (out_m_seed),
    .out_p_divider     (out_p_divider),
    .out_n_divider     (out_n_divider),
    .n_errors          (n_errors),
    .n_waiting         (n_waiting),
    .n_checked         (n_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // ends the run if nothing moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("no request or result moved for %0d cycles", StallLimit);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_target(input logic [MhzW-1:0] mhz);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_target_mhz <= mhz;
    do @(posedge clk); while (!in_ready);
    targets_sent++;
    if (mhz < TargetMin || mhz > TargetMax) out_of_range_sent++;
  endtask

  // wait for every outstanding result, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_waiting != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_ref_clock(input logic [RefW-1:0] khz);
    settle();
    cfg_valid         <= 1'b1;
    cfg_ref_clock_khz <= khz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ref_writes++;
  endtask

  function automatic logic [MhzW-1:0] pick_target();
    if ($urandom_range(99) < InRangePct)
      return MhzW'($urandom_range(TargetMax, TargetMin));
    return MhzW'($urandom_range(MhzTop));
  endfunction

  function automatic logic [RefW-1:0] pick_ref_clock(input int slot);
    case (slot)
      0:       return RefLow;
      1:       return RefHigh;
      2:       return RefW'($urandom_range(RefHigh, RefLow));
      default: return ($urandom_range(3) == 0) ? '0 : RefW'($urandom_range(RefTop));
    endcase
  endfunction

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests at the reset reference clock
    foreach (EdgeTargets[i]) send_target(EdgeTargets[i]);
    // zero reference clock: every candidate is zero, first pair wins
    write_ref_clock('0);
    send_target(MhzW'(775));
    send_target(TargetMax);
    write_ref_clock(RefTop);
    send_target(TargetMin);
    send_target(TargetMax);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   <= 23;
          receiver_idle_pct <= 47;
        end
        1: begin
          sender_idle_pct   <= 47;
          receiver_idle_pct <= 23;
        end
        default: begin
          sender_idle_pct   <= 0;
          receiver_idle_pct <= 0;
        end
      endcase
      for (int slot = 0; slot < SettingsPerPhase; slot++) begin
        write_ref_clock(pick_ref_clock(slot));
        repeat (ItemsPerSetting) send_target(pick_target());
      end
    end

    settle();
    $display("%0d target requests sent, %0d of them out of range, over %0d clock writes",
             targets_sent, out_of_range_sent, ref_writes);
    $display("%0d results compared, %0d mismatches, %0d still outstanding",
             n_checked, n_errors, n_waiting);
    if (n_errors == 0 && n_waiting == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
